### sv/positional_list_insert_delete_assert.svh
// Assertion macros for the positional list block.
// Used by the port checker; depends on clk and rst_n in the including scope.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PLID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/plid_pkg.sv
// Shared types and constants for the positional list block.
// No dependencies; imported by every module of the block.
`default_nettype none
package plid_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    localparam logic [1:0] FN_INS  = 2'd0;
    localparam logic [1:0] FN_DEL  = 2'd1;
    localparam logic [1:0] FN_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  position;
        logic [63:0] in_name;
        logic [7:0]  in_age;
        logic [15:0] in_sex;
        logic [31:0] in_score;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_name;
        logic [7:0]  out_age;
        logic [15:0] out_sex;
        logic [31:0] out_score;
        logic [6:0]  list_count;
        logic        is_empty;
    } rsp_t;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  age;
        logic [15:0] sex;
        logic [31:0] score;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             sel;
        logic [IDX_W-1:0] tgt;
        rec_t             new_rec;
    } cell_ctl_t;

endpackage
`default_nettype wire

### sv/plid_cell.sv
// One list slot: holds a record and shifts it to or from its neighbours.
// Depends on plid_pkg.
`default_nettype none
module plid_cell
    import plid_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [IDX_W-1:0] idx,
    input  wire rec_t             left_rec,
    input  wire rec_t             right_rec,
    output rec_t                  rec,
    output logic [REC_W-1:0]      sel_rec
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.ins)
        begin
            if (idx > ctl.tgt)
                rec_next = left_rec;
            else if (idx == ctl.tgt)
                rec_next = ctl.new_rec;
        end
        else if (ctl.del && idx >= ctl.tgt)
        begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec     = rec_reg;
    assign sel_rec = (ctl.sel && idx == ctl.tgt) ? rec_reg : '0;

endmodule
`default_nettype wire

### sv/positional_list_insert_delete.sv
// Top level of the positional list: row of slot cells, count and result pipeline.
// Depends on plid_pkg and plid_cell.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low; busy
//   stays low, so a request may be issued in every cycle.
//   func selects insert, delete or read at 1-based position; insert takes the
//   record in req. Every request gives exactly one response.
//   The response appears on rsp with done high for one cycle; the request is
//   registered first in v1_reg, st1_reg, cnt1_reg and grp_reg, then in done_reg
//   and rsp_reg, which drive the outputs.
//   Throughput: one request per cycle; all slots shift together in the cycle
//   of the request, and the returned record goes through a two-level
//   registered OR tree over groups of eight slots.
//   Reset clears the entry count and the pipeline valids; slot contents are
//   left as they are and are never returned before being written.
//   The receiver cannot stall: done is a strobe and rsp holds for one cycle.
`default_nettype none
module positional_list_insert_delete
    import plid_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      rsp
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             accept;
    logic [15:0]      pos_w;
    logic [15:0]      fill_w;
    logic [15:0]      tgt_w;
    logic [1:0]       status;
    logic             ins_ok;
    logic             del_ok;
    logic             sel_ok;
    cell_ctl_t        ctl;

    rec_t             cell_rec  [CAPACITY];
    rec_t             left_rec  [CAPACITY];
    rec_t             right_rec [CAPACITY];
    logic [REC_W-1:0] cell_sel  [CAPACITY];

    logic [REC_W-1:0] grp_or    [NGRP];
    logic [REC_W-1:0] grp_reg   [NGRP];
    logic             v1_reg;
    logic [1:0]       st1_reg;
    logic [CNT_W-1:0] cnt1_reg;
    logic [REC_W-1:0] rec_or;
    rec_t             rec_sel;
    logic [CNT_W+6:0] cnt_ext;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pos_w  = {8'd0, req.position};
    assign fill_w = 16'(fill_reg);
    assign tgt_w  = pos_w - 16'd1;

    always_comb
    begin
        status    = ST_RANGE;
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
        sel_ok    = 1'b0;
        case (req.func)
            FN_INS:
            begin
                if (pos_w >= 16'd1 && pos_w <= fill_w + 16'd1)
                begin
                    if (fill_w >= 16'(CAPACITY))
                        status = ST_FULL;
                    else
                    begin
                        status = ST_OK;
                        ins_ok = 1'b1;
                    end
                end
            end
            FN_DEL:
            begin
                if (pos_w >= 16'd1 && pos_w <= fill_w)
                begin
                    status = ST_OK;
                    del_ok = 1'b1;
                    sel_ok = 1'b1;
                end
            end
            FN_READ:
            begin
                if (pos_w >= 16'd1 && pos_w <= fill_w)
                begin
                    status = ST_OK;
                    sel_ok = 1'b1;
                end
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ins_ok)
            fill_next = fill_reg + CNT_W'(1);
        else if (del_ok)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_comb
    begin
        ctl.ins           = accept && ins_ok;
        ctl.del           = accept && del_ok;
        ctl.sel           = accept && sel_ok;
        ctl.tgt           = tgt_w[IDX_W-1:0];
        ctl.new_rec.name  = req.in_name;
        ctl.new_rec.age   = req.in_age;
        ctl.new_rec.sex   = req.in_sex;
        ctl.new_rec.score = req.in_score;
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            left_rec[i]  = (i == 0) ? cell_rec[i] : cell_rec[(i == 0) ? 0 : i - 1];
            right_rec[i] = (i == CAPACITY - 1) ? cell_rec[i]
                         : cell_rec[(i == CAPACITY - 1) ? i : i + 1];
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        plid_cell u_cell
        (
            .clk       (clk),
            .ctl       (ctl),
            .idx       (IDX_W'(i)),
            .left_rec  (left_rec[i]),
            .right_rec (right_rec[i]),
            .rec       (cell_rec[i]),
            .sel_rec   (cell_sel[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_or[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if (g * GRP + j < CAPACITY)
                    grp_or[g] = grp_or[g] | cell_sel[g * GRP + j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                fill_reg <= fill_next;
            v1_reg   <= accept;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_or;
        st1_reg  <= status;
        cnt1_reg <= fill_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        rec_or = '0;
        for (int g = 0; g < NGRP; g++)
            rec_or = rec_or | grp_reg[g];
    end

    assign rec_sel = rec_or;
    assign cnt_ext = {7'd0, cnt1_reg};

    always_comb
    begin
        rsp_next.status     = st1_reg;
        rsp_next.out_name   = rec_sel.name;
        rsp_next.out_age    = rec_sel.age;
        rsp_next.out_sex    = rec_sel.sex;
        rsp_next.out_score  = rec_sel.score;
        rsp_next.list_count = cnt_ext[6:0];
        rsp_next.is_empty   = (cnt1_reg == '0);
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

### sv/plid_check.sv
// Port-level checker for the positional list, bound to the top level.
// Depends on plid_pkg and positional_list_insert_delete_assert.svh.
`default_nettype none
`include "positional_list_insert_delete_assert.svh"
module plid_check
    import plid_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire req_t req,
    input wire logic done,
    input wire rsp_t rsp
);

    `PLID_ASSERT(a_resp_follows, (start && !busy) |=> ##1 done, "request without response")
    `PLID_ASSERT(a_resp_has_req, done |-> $past(start && !busy, 2), "response without request")
    `PLID_ASSERT(a_empty_flag, done |-> (rsp.is_empty == (rsp.list_count == 7'd0)), "empty flag wrong")
    `PLID_ASSERT(a_range_zero, (done && rsp.status == ST_RANGE) |-> (rsp.out_name == 64'd0 && rsp.out_age == 8'd0 && rsp.out_sex == 16'd0 && rsp.out_score == 32'd0), "refused request returned data")
    `PLID_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done, "response during reset")

endmodule

bind positional_list_insert_delete plid_check u_plid_check (.*);
`default_nettype wire
